FILE: sv/pl_pkg.sv
// Package for the positional list engine: operation and status codes,
// default capacity and the input and result beat types. No dependencies.
`timescale 1ns / 1ps

package pl_pkg;

    // Default number of list entries
    localparam int PL_CAPACITY = 64;

    // Operation codes
    localparam logic [2:0] OP_INSERT = 3'd0;
    localparam logic [2:0] OP_DELETE = 3'd1;
    localparam logic [2:0] OP_GET    = 3'd2;
    localparam logic [2:0] OP_LOCATE = 3'd3;
    localparam logic [2:0] OP_PRED   = 3'd4;
    localparam logic [2:0] OP_SUCC   = 3'd5;

    // Status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_EMPTY    = 3'd1;
    localparam logic [2:0] ST_BADPOS   = 3'd2;
    localparam logic [2:0] ST_NOTFOUND = 3'd3;
    localparam logic [2:0] ST_NOPRED   = 3'd4;
    localparam logic [2:0] ST_NOSUCC   = 3'd5;
    localparam logic [2:0] ST_FULL     = 3'd6;

    // Input beat
    typedef struct packed {
        logic [2:0]         op;
        logic [6:0]         position;
        logic signed [31:0] value;
    } pl_in_t;

    // Result beat
    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] value_out;
        logic [6:0]         position_out;
        logic [6:0]         length_out;
    } pl_out_t;

endpackage

FILE: sv/positional_list_engine.sv
// Positional list engine top level: list memory, walk sequencer, result register.
// Depends on pl_pkg.
`timescale 1ns / 1ps

// Ordered list of up to CAPACITY signed 32-bit values addressed by 1-based
// position. One operation per input beat, one result beat per operation.
// The list lives in a single-port-read, single-port-write memory, and one
// sequencer walks it one entry per cycle: insert moves the entries from the
// end down to the position up by one place, delete moves the entries above
// the position down by one, and locate/predecessor/successor compare the
// entries from position 1 upward until the first match. The input is not
// ready while an operation runs; a finished result waits in the output
// register without holding up the next input beat. Reset empties the list;
// no clearing pass is needed.
module positional_list_engine
    import pl_pkg::*;
#(
    parameter int CAPACITY = PL_CAPACITY
)(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  pl_in_t  in_data,
    output logic    out_valid,
    input  logic    out_ready,
    output pl_out_t out_data
);

    localparam int AW = $clog2(CAPACITY);
    localparam int LW = $clog2(CAPACITY + 1);
    localparam int CW = ((LW > 7) ? LW : 7) + 1;

    // Sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_INS   = 3'd1;
    localparam logic [2:0] S_DEL   = 3'd2;
    localparam logic [2:0] S_GET   = 3'd3;
    localparam logic [2:0] S_SCAN  = 3'd4;
    localparam logic [2:0] S_FETCH = 3'd5;
    localparam logic [2:0] S_RESP  = 3'd6;

    logic [2:0]    state_reg, state_next;
    logic [LW-1:0] len_reg, len_next;
    logic [LW-1:0] cnt_reg, cnt_next;
    logic [AW-1:0] ptr_reg, ptr_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [2:0]    op_reg, op_next;
    logic [31:0]   val_reg, val_next;
    logic [31:0]   prev_reg, prev_next;
    pl_out_t       res_reg, res_next;
    logic          out_valid_reg, out_valid_next;
    pl_out_t       out_data_reg, out_data_next;

    // List memory and its registered read port
    logic [31:0]   mem [CAPACITY];
    logic          rd_en;
    logic          rd_valid_reg;
    logic [31:0]   rd_data_reg;
    logic [AW-1:0] rd_addr_reg;
    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic [31:0]   mem_wd;

    logic [CW-1:0] pos_ext;
    logic [CW-1:0] len_ext;
    logic          rd_match;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign pos_ext  = CW'(in_data.position);
    assign len_ext  = CW'(len_reg);
    assign rd_match = rd_valid_reg && (rd_data_reg == val_reg);

    // Walk reads: one entry per cycle while entries remain
    assign rd_en = ((state_reg == S_INS) || (state_reg == S_DEL) ||
                    (state_reg == S_GET) || (state_reg == S_SCAN)) && (cnt_reg != '0);

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        len_next       = len_reg;
        cnt_next       = cnt_reg;
        ptr_next       = ptr_reg;
        idx_next       = idx_reg;
        op_next        = op_reg;
        val_next       = val_reg;
        prev_next      = prev_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        mem_we         = 1'b0;
        mem_wa         = '0;
        mem_wd         = rd_data_reg;

        if (rd_en)
        begin
            cnt_next = cnt_reg - LW'(1);
            ptr_next = (state_reg == S_INS) ? ptr_reg - AW'(1) : ptr_reg + AW'(1);
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next  = in_data.op;
                    val_next = in_data.value;
                    idx_next = AW'(pos_ext - CW'(1));
                    res_next = '{status: ST_OK, value_out: '0,
                                 position_out: '0, length_out: '0};
                    unique case (in_data.op) inside
                        OP_INSERT:
                        begin
                            if ((pos_ext == '0) || (pos_ext > len_ext + CW'(1)))
                            begin
                                res_next.status = ST_BADPOS;
                                state_next      = S_RESP;
                            end
                            else if (len_ext == CW'(CAPACITY))
                            begin
                                res_next.status = ST_FULL;
                                state_next      = S_RESP;
                            end
                            else
                            begin
                                ptr_next   = AW'(len_reg - LW'(1));
                                cnt_next   = len_reg - LW'(pos_ext - CW'(1));
                                state_next = S_INS;
                            end
                        end
                        OP_DELETE, OP_GET:
                        begin
                            if (len_reg == '0)
                            begin
                                res_next.status = ST_EMPTY;
                                state_next      = S_RESP;
                            end
                            else if ((pos_ext == '0) || (pos_ext > len_ext))
                            begin
                                res_next.status = ST_BADPOS;
                                state_next      = S_RESP;
                            end
                            else
                            begin
                                ptr_next = AW'(pos_ext - CW'(1));
                                if (in_data.op == OP_GET)
                                begin
                                    cnt_next   = LW'(1);
                                    state_next = S_GET;
                                end
                                else
                                begin
                                    cnt_next   = len_reg - LW'(pos_ext - CW'(1));
                                    state_next = S_DEL;
                                end
                            end
                        end
                        OP_LOCATE, OP_PRED, OP_SUCC:
                        begin
                            if (len_reg == '0)
                            begin
                                res_next.status = ST_EMPTY;
                                state_next      = S_RESP;
                            end
                            else
                            begin
                                ptr_next   = '0;
                                cnt_next   = len_reg;
                                state_next = S_SCAN;
                            end
                        end
                        default:
                        begin
                            res_next.status = ST_BADPOS;
                            state_next      = S_RESP;
                        end
                    endcase
                end
            end

            // Move entries up one place, then drop the new value in
            S_INS:
            begin
                if (rd_valid_reg)
                begin
                    mem_we = 1'b1;
                    mem_wa = rd_addr_reg + AW'(1);
                end
                else if (cnt_reg == '0)
                begin
                    mem_we     = 1'b1;
                    mem_wa     = idx_reg;
                    mem_wd     = val_reg;
                    len_next   = len_reg + LW'(1);
                    state_next = S_RESP;
                end
            end

            // First read is the deleted entry; the rest move down one place
            S_DEL:
            begin
                if (rd_valid_reg)
                begin
                    if (rd_addr_reg == idx_reg)
                    begin
                        res_next.value_out = rd_data_reg;
                    end
                    else
                    begin
                        mem_we = 1'b1;
                        mem_wa = rd_addr_reg - AW'(1);
                    end
                end
                else if (cnt_reg == '0)
                begin
                    len_next   = len_reg - LW'(1);
                    state_next = S_RESP;
                end
            end

            S_GET:
            begin
                if (rd_valid_reg)
                begin
                    res_next.value_out = rd_data_reg;
                    state_next         = S_RESP;
                end
            end

            // Compare entries in order until the first match
            S_SCAN:
            begin
                if (rd_valid_reg)
                begin
                    prev_next = rd_data_reg;
                    if (rd_match)
                    begin
                        state_next = S_RESP;
                        if (op_reg == OP_LOCATE)
                        begin
                            res_next.position_out = 7'(rd_addr_reg) + 7'd1;
                        end
                        else if (op_reg == OP_PRED)
                        begin
                            if (rd_addr_reg == '0)
                                res_next.status = ST_NOPRED;
                            else
                                res_next.value_out = prev_reg;
                        end
                        else if ((LW'(rd_addr_reg) + LW'(1)) >= len_reg)
                        begin
                            res_next.status = ST_NOSUCC;
                        end
                        else
                        begin
                            // next entry was read in this same cycle
                            state_next = S_FETCH;
                        end
                    end
                end
                else if (cnt_reg == '0)
                begin
                    res_next.status = ST_NOTFOUND;
                    state_next      = S_RESP;
                end
            end

            S_FETCH:
            begin
                if (rd_valid_reg)
                begin
                    res_next.value_out = rd_data_reg;
                    state_next         = S_RESP;
                end
            end

            // Hand the result to the output register once it is free
            S_RESP:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Length reported is the one after the operation
        if ((state_next == S_RESP) && (state_reg != S_RESP))
            res_next.length_out = 7'(len_next);
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            len_reg       <= '0;
            cnt_reg       <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            cnt_reg       <= cnt_next;
            rd_valid_reg  <= rd_en;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        ptr_reg      <= ptr_next;
        idx_reg      <= idx_next;
        op_reg       <= op_next;
        val_reg      <= val_next;
        prev_reg     <= prev_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

    // List memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        if (rd_en)
        begin
            rd_data_reg <= mem[ptr_reg];
            rd_addr_reg <= ptr_reg;
        end
    end

    // Checks
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_ext <= CW'(CAPACITY))
        else $error("list length above capacity");

    a_len_change: assert property (@(posedge clk) disable iff (!rst_n)
        (len_reg != $past(len_reg)) |-> (state_reg == S_RESP))
        else $error("length changed outside completion");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_IDLE) || (state_reg == S_RESP)) |-> !mem_we)
        else $error("memory write while not walking");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input ready right after accept");

    a_resp_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_RESP) && (state_next == S_IDLE)) |=> out_valid)
        else $error("result not presented");

endmodule

FILE: tb/positional_list_engine_tb.sv
// Self-checking testbench for positional_list_engine: directed and random list
// operations, with a scoreboard that runs its own copy of the list.
// Depends on pl_pkg and positional_list_engine.
`timescale 1ns / 1ps

module positional_list_engine_tb;
    import pl_pkg::*;

    // Op codes the block leaves unused
    localparam logic [2:0] OP_SPARE_A = 3'd6;
    localparam logic [2:0] OP_SPARE_B = 3'd7;

    // Which copy of the list a call works on
    localparam int GEN_COPY = 0;
    localparam int CHK_COPY = 1;

    // Random phase kinds
    localparam int PH_GROW   = 0;
    localparam int PH_SHRINK = 1;
    localparam int PH_MIXED  = 2;

    logic    clk       = 1'b0;
    logic    rst_n     = 1'b0;
    logic    in_valid  = 1'b0;
    logic    in_ready;
    pl_in_t  in_data   = '0;
    logic    out_valid;
    logic    out_ready = 1'b0;
    pl_out_t out_data;

    // List copies: one follows the generator, one follows accepted beats
    logic signed [31:0] list_vals [2][PL_CAPACITY];
    int                 list_len  [2] = '{0, 0};

    pl_in_t  op_beat_q [$];
    pl_out_t list_result_q [$];

    logic in_took  = 1'b0;
    logic out_took = 1'b0;
    int   tx_gap   = 0;
    logic burst_tx = 1'b0;
    int   rx_wait  = 0;
    logic burst_rx = 1'b0;
    logic long_hold_done = 1'b0;
    int   results_checked = 0;
    int   n_errors = 0;

    positional_list_engine dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #5 clk = ~clk;

    // Apply one operation to list copy w and return the result it gives
    function automatic pl_out_t list_op_result(input int w, input pl_in_t b);
        pl_out_t r;
        int      len;
        int      p;
        int      i;
        int      k;
        r   = '0;
        len = list_len[w];
        p   = int'(b.position);
        case (b.op)
            OP_INSERT:
            begin
                if (p < 1 || p > len + 1)
                    r.status = ST_BADPOS;
                else if (len >= PL_CAPACITY)
                    r.status = ST_FULL;
                else
                begin
                    for (i = len; i > p - 1; i--)
                        list_vals[w][i] = list_vals[w][i - 1];
                    list_vals[w][p - 1] = b.value;
                    list_len[w] = len + 1;
                end
            end
            OP_DELETE, OP_GET:
            begin
                if (len == 0)
                    r.status = ST_EMPTY;
                else if (p < 1 || p > len)
                    r.status = ST_BADPOS;
                else
                begin
                    r.value_out = list_vals[w][p - 1];
                    if (b.op == OP_DELETE)
                    begin
                        for (i = p - 1; i + 1 < len; i++)
                            list_vals[w][i] = list_vals[w][i + 1];
                        list_len[w] = len - 1;
                    end
                end
            end
            OP_LOCATE, OP_PRED, OP_SUCC:
            begin
                if (len == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    // first match wins
                    k = 0;
                    while (k < len && list_vals[w][k] != b.value)
                        k++;
                    if (k == len)
                        r.status = ST_NOTFOUND;
                    else if (b.op == OP_LOCATE)
                        r.position_out = 7'(k + 1);
                    else if (b.op == OP_PRED)
                    begin
                        if (k == 0)
                            r.status = ST_NOPRED;
                        else
                            r.value_out = list_vals[w][k - 1];
                    end
                    else if (k + 1 >= len)
                        r.status = ST_NOSUCC;
                    else
                        r.value_out = list_vals[w][k + 1];
                end
            end
            default:
                r.status = ST_BADPOS;
        endcase
        r.length_out = 7'(list_len[w]);
        return r;
    endfunction

    // Queue one beat for the driver and track its effect on the generator copy
    task automatic queue_op(input logic [2:0] op, input int pos, input logic signed [31:0] val);
        pl_in_t b;
        b.op       = op;
        b.position = 7'(pos);
        b.value    = val;
        op_beat_q.push_back(b);
        void'(list_op_result(GEN_COPY, b));
    endtask

    // One random beat, biased by the phase kind
    task automatic queue_random(input int kind);
        int                 len;
        int                 r;
        int                 pos;
        logic [2:0]         op;
        logic signed [31:0] val;
        len = list_len[GEN_COPY];
        r   = $urandom_range(0, 99);
        if (r < 2)
            op = ($urandom_range(0, 1) == 0) ? OP_SPARE_A : OP_SPARE_B;
        else if (r < (kind == PH_GROW ? 70 : kind == PH_SHRINK ? 15 : 32))
            op = OP_INSERT;
        else if (r < (kind == PH_GROW ? 78 : kind == PH_SHRINK ? 65 : 60))
            op = OP_DELETE;
        else if (r < (kind == PH_GROW ? 85 : kind == PH_SHRINK ? 75 : 72))
            op = OP_GET;
        else
        begin
            case ($urandom_range(0, 2))
                0:       op = OP_LOCATE;
                1:       op = OP_PRED;
                default: op = OP_SUCC;
            endcase
        end

        // mostly legal positions, with the edges and full-range noise mixed in
        r = $urandom_range(0, 99);
        if (r < 80)
            pos = (op == OP_INSERT) ? $urandom_range(1, len + 1)
                                    : (len == 0 ? 1 : $urandom_range(1, len));
        else if (r < 85)
            pos = 0;
        else if (r < 90)
            pos = len + 1 + $urandom_range(0, 1);
        else
            pos = $urandom_range(0, 127);

        // searches mostly hit a stored value; a small pool makes duplicates
        r = $urandom_range(0, 99);
        if (op != OP_INSERT && len > 0 && r < 75)
            val = list_vals[GEN_COPY][$urandom_range(0, len - 1)];
        else if (r < 80)
            val = 32'sh8000_0000;
        else if (r < 85)
            val = 32'sh7fff_ffff;
        else if (r < 92)
            val = $signed($urandom_range(0, 7)) - 4;
        else
            val = $urandom;
        queue_op(op, pos, val);
    endtask

    task automatic wait_drained();
        while (op_beat_q.size() != 0 || in_valid || list_result_q.size() != 0)
            @(posedge clk);
    endtask

    // Driver: offer beats from the pending queue with random gaps
    always @(negedge clk)
    begin
        if (rst_n && !(in_valid && !in_took))
        begin
            if (tx_gap != 0)
            begin
                in_valid <= 1'b0;
                tx_gap   <= tx_gap - 1;
            end
            else if (op_beat_q.size() != 0)
            begin
                in_valid <= 1'b1;
                in_data  <= op_beat_q.pop_front();
                tx_gap   <= burst_tx ? 0 : $urandom_range(0, 15);
                if ($urandom_range(0, 63) == 0)
                    burst_tx <= ~burst_tx;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver: random stall after each taken beat, one long hold-off
    always @(negedge clk)
    begin : rx_proc
        int w;
        if (rst_n)
        begin
            if (out_took)
            begin
                if (!long_hold_done && results_checked >= 300)
                begin
                    w = 600;
                    long_hold_done <= 1'b1;
                end
                else
                    w = burst_rx ? 0 : $urandom_range(0, 15);
                if ($urandom_range(0, 63) == 0)
                    burst_rx <= ~burst_rx;
                out_ready <= (w == 0);
                rx_wait   <= (w == 0) ? 0 : w - 1;
            end
            else if (rx_wait != 0)
            begin
                out_ready <= 1'b0;
                rx_wait   <= rx_wait - 1;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Monitor: check result beats, predict on accepted input beats
    always @(posedge clk)
    begin : mon_proc
        pl_out_t want;
        in_took  <= in_valid && in_ready;
        out_took <= out_valid && out_ready;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (list_result_q.size() == 0)
                begin
                    $display("%0t: unexpected result beat: st %0d val %0d pos %0d len %0d",
                             $time, out_data.status, out_data.value_out,
                             out_data.position_out, out_data.length_out);
                    n_errors++;
                end
                else
                begin
                    want = list_result_q.pop_front();
                    if (out_data !== want)
                    begin
                        $display("%0t: mismatch exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                                 $time, want.status, want.value_out, want.position_out,
                                 want.length_out, out_data.status, out_data.value_out,
                                 out_data.position_out, out_data.length_out);
                        n_errors++;
                    end
                end
                results_checked++;
            end
            if (in_valid && in_ready)
                list_result_q.push_back(list_op_result(CHK_COPY, in_data));
        end
    end

    // Stimulus
    initial
    begin
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        // empty list
        queue_op(OP_DELETE, 1, 0);
        queue_op(OP_GET,    0, 0);
        queue_op(OP_LOCATE, 1, 0);
        queue_op(OP_PRED,   1, 0);
        queue_op(OP_SUCC,   1, 0);
        queue_op(OP_INSERT, 0, 1);
        queue_op(OP_INSERT, 2, 1);
        // build [0, min, max]
        queue_op(OP_INSERT, 1, 32'sh8000_0000);
        queue_op(OP_INSERT, 2, 32'sh7fff_ffff);
        queue_op(OP_INSERT, 1, 0);
        queue_op(OP_INSERT, 127, -1);
        queue_op(OP_GET,    4, 0);
        queue_op(OP_GET,    3, 0);
        // searches: hit, first and last entry, absent
        queue_op(OP_LOCATE, 0, 32'sh8000_0000);
        queue_op(OP_PRED,   0, 0);
        queue_op(OP_SUCC,   0, 32'sh7fff_ffff);
        queue_op(OP_PRED,   0, 32'sh7fff_ffff);
        queue_op(OP_SUCC,   0, 0);
        queue_op(OP_LOCATE, 0, 5);
        queue_op(OP_SUCC,   0, -1);
        queue_op(OP_SPARE_A, 1, 0);
        queue_op(OP_SPARE_B, 1, 0);
        queue_op(OP_DELETE, 0, 0);
        queue_op(OP_DELETE, 4, 0);
        queue_op(OP_DELETE, 2, 0);
        wait_drained();

        // fill past capacity, drain to empty, then churn
        repeat (200) queue_random(PH_GROW);
        repeat (180) queue_random(PH_SHRINK);
        repeat (300) queue_random(PH_MIXED);
        wait_drained();
        repeat (200) queue_random(PH_GROW);
        repeat (350) queue_random(PH_MIXED);
        repeat (200) queue_random(PH_SHRINK);
        repeat (370) queue_random(PH_MIXED);

        while (op_beat_q.size() != 0 || in_valid)
            @(posedge clk);
        while (list_result_q.size() != 0)
            @(posedge clk);
        repeat (2 * PL_CAPACITY) @(posedge clk);
        if (n_errors == 0)
            $display("positional_list_engine_tb passed");
        else
            $display("positional_list_engine_tb failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #6_000_000;
        $display("positional_list_engine_tb failed");
        $finish;
    end

endmodule

FILE: positional_list_engine.f
sv/pl_pkg.sv
sv/positional_list_engine.sv
tb/positional_list_engine_tb.sv
